/* hw/rtl/tmer_pkg.sv */
// ----------------------------------------------------------------------------
// tmer_pkg: shared types and constants
// Record layout, store sizing, the job descriptor handed from the loader to
// the selection engine, and the selection engine's states.
// ----------------------------------------------------------------------------
package tmer_pkg;

  localparam int MAX_RECORDS = 1024;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  // radius r = factor (Q8.8) * h (Q15.16) is 47 bits; r^2 is 94 bits
  localparam int R_W   = 47;
  localparam int RL_W  = 24;
  localparam int R2_W  = 94;
  // dx^2 + dy^2 with 32-bit magnitudes
  localparam int SQ_W  = 65;

  localparam logic [15:0]      EXCL_RESET = 16'd512;
  localparam logic [CNT_W-1:0] MAX_COUNT  = CNT_W'(MAX_RECORDS);

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] size;
  } record_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    record_t           rec;
  } wr_port_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_P1,
    B_FRD,
    B_R0,
    B_R1,
    B_R2,
    B_R3,
    B_R4,
    B_P2RD,
    B_P2DIF,
    B_P2MX,
    B_P2MY,
    B_P2ADD,
    B_P2CMP,
    B_EMIT
  } back_state_t;

endpackage

/* hw/rtl/tmer_front.sv */
// ----------------------------------------------------------------------------
// tmer_front: record loader
// Accept records, write them to the record store, count them, and post one
// job per set when the last record arrives.
// ----------------------------------------------------------------------------
module tmer_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  candidate_value,
  input  logic signed [31:0]  candidate_x,
  input  logic signed [31:0]  candidate_y,
  input  logic [30:0]         candidate_size,
  input  logic                is_last,
  input  logic                hold,
  output tmer_pkg::wr_port_t  wr,
  output logic                push,
  output tmer_pkg::job_t      push_job
);

  logic [tmer_pkg::CNT_W-1:0] count;
  logic                       ovf;
  logic                       accept;
  logic                       stored;

  assign in_ready = ~hold;
  assign accept   = in_valid & in_ready;
  assign stored   = (count != tmer_pkg::MAX_COUNT);

  assign wr.en        = accept & stored;
  assign wr.addr      = count[tmer_pkg::ADDR_W-1:0];
  assign wr.rec.value = candidate_value;
  assign wr.rec.x     = candidate_x;
  assign wr.rec.y     = candidate_y;
  assign wr.rec.size  = candidate_size;

  assign push           = accept & is_last;
  assign push_job.count = stored ? count + tmer_pkg::CNT_W'(1) : count;
  assign push_job.ovf   = ovf | ~stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        count <= '0;
        ovf   <= 1'b0;
      end else if (stored) begin
        count <= count + tmer_pkg::CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/tmer_job_queue.sv */
// ----------------------------------------------------------------------------
// tmer_job_queue: two-entry job queue
// Hold finished sets between the loader and the selection engine.
// ----------------------------------------------------------------------------
module tmer_job_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tmer_pkg::job_t  push_job,
  input  logic            pop,
  output tmer_pkg::job_t  head,
  output logic            not_empty,
  output logic            full
);

  tmer_pkg::job_t slots [2];
  logic           wp;
  logic           rp;
  logic [1:0]     fill;
  logic           push_ok;
  logic           pop_ok;

  assign not_empty = (fill != 2'd0);
  assign full      = (fill == 2'd2);
  assign push_ok   = push & ~full;
  assign pop_ok    = pop & not_empty;
  assign head      = slots[rp];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push_ok) begin
        wp <= ~wp;
      end
      if (pop_ok) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push_ok) - 2'(pop_ok);
    end
  end

endmodule

/* hw/rtl/tmer_back.sv */
// ----------------------------------------------------------------------------
// tmer_back: selection engine
// Own the record store; per job, scan for the smallest value, build the
// squared exclusion radius, then scan again for the smallest value outside it.
// ----------------------------------------------------------------------------
module tmer_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         excl_factor,
  input  tmer_pkg::wr_port_t  wr,
  input  logic                job_valid,
  input  tmer_pkg::job_t      job,
  output logic                job_pop,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  first_value,
  output logic signed [31:0]  first_x,
  output logic signed [31:0]  first_y,
  output logic signed [31:0]  second_value,
  output logic signed [31:0]  second_x,
  output logic signed [31:0]  second_y,
  output logic                second_found,
  output logic                overflowed
);

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32]) begin
      d = -d;
    end
    return d[31:0];
  endfunction

  tmer_pkg::back_state_t       state;
  tmer_pkg::back_state_t       state_next;

  tmer_pkg::record_t           mem [tmer_pkg::MAX_RECORDS];
  tmer_pkg::record_t           rd;
  logic [tmer_pkg::ADDR_W-1:0] rd_addr;

  logic [tmer_pkg::CNT_W-1:0]  n;
  logic                        ovf;
  logic [tmer_pkg::CNT_W-1:0]  p1_issue;
  logic                        p1_pend;
  logic [tmer_pkg::ADDR_W-1:0] p1_pidx;
  logic [31:0]                 minv;
  logic [tmer_pkg::ADDR_W-1:0] first;
  logic [31:0]                 fv;
  logic [31:0]                 fx;
  logic [31:0]                 fy;

  logic [31:0]                 mul_a;
  logic [31:0]                 mul_b;
  logic [63:0]                 mul_p;
  logic [63:0]                 prod;
  logic [tmer_pkg::R_W-1:0]    rr;
  logic [tmer_pkg::R2_W-1:0]   r2;

  logic [tmer_pkg::CNT_W-1:0]  j;
  logic [31:0]                 dx;
  logic [31:0]                 dy;
  logic [31:0]                 cv;
  logic [31:0]                 cx;
  logic [31:0]                 cy;
  logic [tmer_pkg::SQ_W-1:0]   acc;
  logic                        found;
  logic [31:0]                 sv;
  logic [31:0]                 sx;
  logic [31:0]                 sy;
  logic                        emit;

  assign busy  = (state != tmer_pkg::B_IDLE);
  assign mul_p = mul_a * mul_b;
  assign emit  = (state == tmer_pkg::B_EMIT) & (~out_valid | out_ready);

  // record store: one write port (loader), one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.rec;
    end
    rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmer_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    job_pop    = 1'b0;
    mul_a      = dx;
    mul_b      = dx;
    case (state)
      tmer_pkg::B_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = tmer_pkg::B_P1;
        end
      end
      tmer_pkg::B_P1: begin
        rd_addr = p1_issue[tmer_pkg::ADDR_W-1:0];
        if ((p1_issue == n) && !p1_pend) begin
          state_next = tmer_pkg::B_FRD;
        end
      end
      tmer_pkg::B_FRD: begin
        rd_addr    = first;
        state_next = tmer_pkg::B_R0;
      end
      tmer_pkg::B_R0: begin
        mul_a      = {16'd0, excl_factor};
        mul_b      = {1'b0, rd.size};
        state_next = tmer_pkg::B_R1;
      end
      tmer_pkg::B_R1: begin
        mul_a      = {8'd0, prod[tmer_pkg::RL_W-1:0]};
        mul_b      = {8'd0, prod[tmer_pkg::RL_W-1:0]};
        state_next = tmer_pkg::B_R2;
      end
      tmer_pkg::B_R2: begin
        mul_a      = {9'd0, rr[tmer_pkg::R_W-1:tmer_pkg::RL_W]};
        mul_b      = {8'd0, rr[tmer_pkg::RL_W-1:0]};
        state_next = tmer_pkg::B_R3;
      end
      tmer_pkg::B_R3: begin
        mul_a      = {9'd0, rr[tmer_pkg::R_W-1:tmer_pkg::RL_W]};
        mul_b      = {9'd0, rr[tmer_pkg::R_W-1:tmer_pkg::RL_W]};
        state_next = tmer_pkg::B_R4;
      end
      tmer_pkg::B_R4: begin
        state_next = tmer_pkg::B_P2RD;
      end
      tmer_pkg::B_P2RD: begin
        rd_addr = j[tmer_pkg::ADDR_W-1:0];
        if (j == n) begin
          state_next = tmer_pkg::B_EMIT;
        end else if (j[tmer_pkg::ADDR_W-1:0] != first) begin
          state_next = tmer_pkg::B_P2DIF;
        end
      end
      tmer_pkg::B_P2DIF: begin
        state_next = tmer_pkg::B_P2MX;
      end
      tmer_pkg::B_P2MX: begin
        state_next = tmer_pkg::B_P2MY;
      end
      tmer_pkg::B_P2MY: begin
        mul_a      = dy;
        mul_b      = dy;
        state_next = tmer_pkg::B_P2ADD;
      end
      tmer_pkg::B_P2ADD: begin
        state_next = tmer_pkg::B_P2CMP;
      end
      tmer_pkg::B_P2CMP: begin
        state_next = tmer_pkg::B_P2RD;
      end
      tmer_pkg::B_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = tmer_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = tmer_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      tmer_pkg::B_IDLE: begin
        n        <= job.count;
        ovf      <= job.ovf;
        p1_issue <= '0;
        p1_pend  <= 1'b0;
        p1_pidx  <= '0;
        first    <= '0;
        found    <= 1'b0;
      end
      tmer_pkg::B_P1: begin
        if (p1_issue != n) begin
          p1_issue <= p1_issue + tmer_pkg::CNT_W'(1);
          p1_pend  <= 1'b1;
          p1_pidx  <= p1_issue[tmer_pkg::ADDR_W-1:0];
        end else begin
          p1_pend <= 1'b0;
        end
        // earliest wins on ties: replace only on strictly smaller
        if (p1_pend && ((p1_pidx == '0) || ($signed(rd.value) < $signed(minv)))) begin
          minv  <= rd.value;
          first <= p1_pidx;
        end
      end
      tmer_pkg::B_R0: begin
        prod <= mul_p;
        fv   <= rd.value;
        fx   <= rd.x;
        fy   <= rd.y;
      end
      tmer_pkg::B_R1: begin
        rr   <= prod[tmer_pkg::R_W-1:0];
        prod <= mul_p;
      end
      tmer_pkg::B_R2: begin
        r2   <= tmer_pkg::R2_W'(prod);
        prod <= mul_p;
      end
      tmer_pkg::B_R3: begin
        // cross term counts twice
        r2   <= r2 + (tmer_pkg::R2_W'(prod) << (tmer_pkg::RL_W + 1));
        prod <= mul_p;
      end
      tmer_pkg::B_R4: begin
        r2 <= r2 + (tmer_pkg::R2_W'(prod) << (2 * tmer_pkg::RL_W));
        j  <= '0;
      end
      tmer_pkg::B_P2RD: begin
        if ((j != n) && (j[tmer_pkg::ADDR_W-1:0] == first)) begin
          j <= j + tmer_pkg::CNT_W'(1);
        end
      end
      tmer_pkg::B_P2DIF: begin
        dx <= abs_diff(rd.x, fx);
        dy <= abs_diff(rd.y, fy);
        cv <= rd.value;
        cx <= rd.x;
        cy <= rd.y;
      end
      tmer_pkg::B_P2MX: begin
        prod <= mul_p;
      end
      tmer_pkg::B_P2MY: begin
        prod <= mul_p;
        acc  <= tmer_pkg::SQ_W'(prod);
      end
      tmer_pkg::B_P2ADD: begin
        acc <= acc + tmer_pkg::SQ_W'(prod);
      end
      tmer_pkg::B_P2CMP: begin
        // Q33.32 squared distance scaled to Q46.48 against the squared radius
        if ((tmer_pkg::R2_W'({acc, 16'd0}) > r2) &&
            (!found || ($signed(cv) < $signed(sv)))) begin
          found <= 1'b1;
          sv    <= cv;
          sx    <= cx;
          sy    <= cy;
        end
        j <= j + tmer_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      first_value  <= fv;
      first_x      <= fx;
      first_y      <= fy;
      second_value <= found ? sv : 32'd0;
      second_x     <= found ? sx : 32'd0;
      second_y     <= found ? sy : 32'd0;
      second_found <= found;
      overflowed   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/two_minima_with_exclusion_radius_unit.sv */
// ----------------------------------------------------------------------------
// two_minima_with_exclusion_radius_unit: two minima with exclusion radius
// Load a set of records, then report the smallest value and the smallest
// value lying strictly outside factor*h of the first minimum.
// ----------------------------------------------------------------------------
// Records stream in one per cycle when not held off and are written to a 1024-entry store.
// The record flagged is_last closes the set; up to 1024 records are kept and
// any beyond that are dropped and reported through overflowed. Selection
// runs on the single store read port and shared 32x32 multiplier: it takes
// the job, scans for the minimum, builds the squared radius, then scans
// every record but the first minimum for the one outside the radius with
// the smallest value. The input stalls from the last record of a set until
// its selection has finished; after that a new set loads while the result
// waits in the output register. exclusion_factor (unsigned Q8.8, reset
// 2.0) is written through the cfg channel; the user must write it only
// while the unit is idle, as the block does not enforce this. Ties on
// value go to the earliest record; with no record outside the radius the
// second fields read zero and second_found is low.
// ----------------------------------------------------------------------------
module two_minima_with_exclusion_radius_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] candidate_value,
  input  logic signed [31:0] candidate_x,
  input  logic signed [31:0] candidate_y,
  input  logic [30:0]        candidate_size,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] first_value,
  output logic signed [31:0] first_x,
  output logic signed [31:0] first_y,
  output logic signed [31:0] second_value,
  output logic signed [31:0] second_x,
  output logic signed [31:0] second_y,
  output logic               second_found,
  output logic               overflowed
);

  logic [15:0]        excl_factor;
  tmer_pkg::wr_port_t wr;
  logic               q_push;
  tmer_pkg::job_t     q_push_job;
  logic               q_pop;
  tmer_pkg::job_t     q_head;
  logic               q_not_empty;
  logic               q_full;
  logic               back_busy;
  logic               hold;

  // config register: always ready; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      excl_factor <= tmer_pkg::EXCL_RESET;
    end else if (cfg_valid) begin
      excl_factor <= cfg_data;
    end
  end

  // hold the loader while a closed set waits or is being scanned, so the
  // store is never overwritten under the selection engine
  assign hold = q_not_empty | back_busy;

  tmer_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .candidate_value (candidate_value),
    .candidate_x     (candidate_x),
    .candidate_y     (candidate_y),
    .candidate_size  (candidate_size),
    .is_last         (is_last),
    .hold            (hold),
    .wr              (wr),
    .push            (q_push),
    .push_job        (q_push_job)
  );

  tmer_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_push_job),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  tmer_back u_back (
    .clk          (clk),
    .rst          (rst),
    .excl_factor  (excl_factor),
    .wr           (wr),
    .job_valid    (q_not_empty),
    .job          (q_head),
    .job_pop      (q_pop),
    .busy         (back_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_value  (first_value),
    .first_x      (first_x),
    .first_y      (first_y),
    .second_value (second_value),
    .second_x     (second_x),
    .second_y     (second_y),
    .second_found (second_found),
    .overflowed   (overflowed)
  );

  // a closed set must never be lost to a full queue
  a_queue_no_overflow: assert property (
    @(posedge clk) disable iff (rst) q_push |-> !q_full
  ) else $error("job queue overflow");

  // taking a job starts the selection engine
  a_pop_starts_engine: assert property (
    @(posedge clk) disable iff (rst) q_pop |=> back_busy
  ) else $error("selection engine did not start on job pop");

  // no second minimum means zeroed second fields
  a_second_zero: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && !second_found) |->
      (second_value == 32'sd0 && second_x == 32'sd0 && second_y == 32'sd0)
  ) else $error("second fields not zero without a second minimum");

endmodule
